// File: src/kpt_pkg.sv
`default_nettype none

package kpt_pkg;

    localparam int POLICY_W = 8;
    localparam int KEY_W    = 32;

    typedef logic [POLICY_W-1:0] policy_t;
    typedef logic [KEY_W-1:0]    key_t;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_UPDATE = 2'd1,
        OP_CLEAR  = 2'd2
    } op_t;

    typedef struct packed {
        op_t     op;
        key_t    control_id;
        key_t    action_code;
        policy_t policy_value;
    } req_t;

    typedef struct packed {
        policy_t policy_out;
        logic    status;
    } rsp_t;

endpackage

`default_nettype wire

// File: src/kpt_ram.sv
`default_nettype none

module kpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: src/keyed_policy_table.sv
// keyed_policy_table: associative table from (control_id, action_code) to a
// policy code, held in one synchronous RAM of TABLE_ENTRIES words.
//
// Request channel: req is taken at a rising edge with start high and busy
// low. Ops: lookup, update (store, remove with policy 0, or insert into the
// lowest free entry), clear. Unused op codes change nothing.
// Response channel: rsp is valid for exactly one cycle while done is high;
// the receiver cannot stall it. status is 1 when an insert found the table
// full.
//
// Lookup and update run a scan that reads one RAM entry per cycle, then
// pass through S_DRAIN and S_FINISH before done. Clear makes one RAM write
// per entry. An unused op code answers in the cycle after it is taken.
// busy stays high until done is shown, so the next request can be taken in
// the cycle done is high.
//
// Reset: after rst_n releases, a clearing pass writes every entry invalid;
// busy is high during it and no request is taken.
`default_nettype none

module keyed_policy_table #(
    parameter int TABLE_ENTRIES = 64,
    parameter int POLICY_BITS   = 8
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire kpt_pkg::req_t req,
    output logic               done,
    output kpt_pkg::rsp_t      rsp
);

    import kpt_pkg::*;

    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int PW = (POLICY_BITS < POLICY_W) ? POLICY_BITS : POLICY_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);

    typedef struct packed {
        logic          valid;
        key_t          ctl;
        key_t          act;
        logic [PW-1:0] pol;
    } entry_t;

    localparam int EW = $bits(entry_t);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FINISH,
        S_CLEAR
    } state_t;

    state_t        state_reg, state_next;
    logic [IW-1:0] cnt_reg, cnt_next;
    logic          dv_reg, dv_next;
    logic          hit_reg, hit_next;
    logic          free_reg, free_next;
    logic          done_reg, done_next;
    rsp_t          rsp_reg, rsp_next;
    req_t          req_reg, req_next;
    logic [IW-1:0] didx_reg, didx_next;
    logic [IW-1:0] hit_idx_reg, hit_idx_next;
    logic [IW-1:0] free_idx_reg, free_idx_next;
    logic [PW-1:0] hit_pol_reg, hit_pol_next;

    logic          we;
    logic [IW-1:0] waddr;
    entry_t        wdata;
    logic [IW-1:0] raddr;
    logic [EW-1:0] rdata;
    entry_t        ent;
    logic [PW-1:0] pol_in;

    kpt_ram #(
        .WIDTH(EW),
        .DEPTH(TABLE_ENTRIES)
    ) u_ram (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(raddr),
        .rdata(rdata)
    );

    assign ent    = entry_t'(rdata);
    assign pol_in = req_reg.policy_value[PW-1:0];
    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign rsp    = rsp_reg;

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        dv_next       = 1'b0;
        hit_next      = hit_reg;
        free_next     = free_reg;
        done_next     = 1'b0;
        rsp_next      = rsp_reg;
        req_next      = req_reg;
        didx_next     = didx_reg;
        hit_idx_next  = hit_idx_reg;
        free_idx_next = free_idx_reg;
        hit_pol_next  = hit_pol_reg;
        we            = 1'b0;
        waddr         = cnt_reg;
        wdata         = '0;
        raddr         = cnt_reg;

        if (dv_reg)
        begin
            if (ent.valid && ent.ctl == req_reg.control_id
                && ent.act == req_reg.action_code)
            begin
                hit_next     = 1'b1;
                hit_idx_next = didx_reg;
                hit_pol_next = ent.pol;
            end
            if (!ent.valid && !free_reg)
            begin
                free_next     = 1'b1;
                free_idx_next = didx_reg;
            end
        end

        case (state_reg)
            S_INIT, S_CLEAR:
            begin
                we       = 1'b1;
                waddr    = cnt_reg;
                wdata    = '0;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_IDX)
                begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                    if (state_reg == S_CLEAR)
                    begin
                        done_next = 1'b1;
                        rsp_next  = '0;
                    end
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    req_next  = req;
                    cnt_next  = '0;
                    hit_next  = 1'b0;
                    free_next = 1'b0;
                    case (req.op)
                        OP_LOOKUP, OP_UPDATE: state_next = S_SCAN;
                        OP_CLEAR:             state_next = S_CLEAR;
                        default:
                        begin
                            done_next = 1'b1;
                            rsp_next  = '0;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                raddr     = cnt_reg;
                dv_next   = 1'b1;
                didx_next = cnt_reg;
                if (cnt_reg == LAST_IDX)
                begin
                    cnt_next   = '0;
                    state_next = S_DRAIN;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_DRAIN:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                done_next  = 1'b1;
                rsp_next   = '0;
                state_next = S_IDLE;
                case (req_reg.op)
                    OP_LOOKUP:
                    begin
                        if (hit_reg)
                        begin
                            rsp_next.policy_out = policy_t'(hit_pol_reg);
                        end
                    end
                    OP_UPDATE:
                    begin
                        if (hit_reg)
                        begin
                            we    = 1'b1;
                            waddr = hit_idx_reg;
                            wdata = '{valid: (pol_in != '0), ctl: req_reg.control_id,
                                      act: req_reg.action_code, pol: pol_in};
                        end
                        else if (pol_in != '0)
                        begin
                            if (free_reg)
                            begin
                                we    = 1'b1;
                                waddr = free_idx_reg;
                                wdata = '{valid: 1'b1, ctl: req_reg.control_id,
                                          act: req_reg.action_code, pol: pol_in};
                            end
                            else
                            begin
                                rsp_next.status = 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            cnt_reg   <= '0;
            dv_reg    <= 1'b0;
            hit_reg   <= 1'b0;
            free_reg  <= 1'b0;
            done_reg  <= 1'b0;
            rsp_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            dv_reg    <= dv_next;
            hit_reg   <= hit_next;
            free_reg  <= free_next;
            done_reg  <= done_next;
            rsp_reg   <= rsp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        didx_reg     <= didx_next;
        hit_idx_reg  <= hit_idx_next;
        free_idx_reg <= free_idx_next;
        hit_pol_reg  <= hit_pol_next;
    end

endmodule

`default_nettype wire

// File: src/kpt_checker.sv
`default_nettype none

module kpt_checker (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          start,
    input wire logic          busy,
    input wire kpt_pkg::req_t req,
    input wire logic          done,
    input wire kpt_pkg::rsp_t rsp
);

    import kpt_pkg::*;

    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted request neither busy nor done next cycle");

    a_done_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(start && !busy) || $past(busy)))
        else $error("done without a request in flight");

    a_status_no_policy: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.status) |-> (rsp.policy_out == '0))
        else $error("full flag together with a policy");

    a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && req.op == OP_CLEAR) |=> busy)
        else $error("clear request did not hold busy");

endmodule

bind keyed_policy_table kpt_checker u_kpt_checker (.*);

`default_nettype wire

// File: bench/tb_keyed_policy_table.sv
`default_nettype none

module tb_keyed_policy_table;
    timeunit 1ns;
    timeprecision 1ps;

    import kpt_pkg::*;

    localparam int      TABLE_ENTRIES = 64;
    localparam int      POLICY_BITS   = 8;
    localparam int      KEY_POOL      = 96;
    localparam int      DRAIN_CYCLES  = TABLE_ENTRIES + 8;
    localparam int      RANDOM_ITEMS  = 1750;
    localparam op_t     OP_UNUSED     = op_t'(2'd3);
    localparam key_t    KEY_ONES      = '1;
    localparam policy_t POLICY_MASK   = policy_t'((64'd1 << POLICY_BITS) - 1);

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic done;
    req_t req;
    rsp_t rsp;

    logic    shadow_valid  [TABLE_ENTRIES];
    key_t    shadow_ctl    [TABLE_ENTRIES];
    key_t    shadow_act    [TABLE_ENTRIES];
    policy_t shadow_policy [TABLE_ENTRIES];

    key_t pool_ctl [KEY_POOL];
    key_t pool_act [KEY_POOL];

    rsp_t pending_rsp [$];
    int   mismatch_count = 0;
    int   burst_left     = 0;

    keyed_policy_table #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .POLICY_BITS   (POLICY_BITS)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("tb_keyed_policy_table failed");
        $finish;
    end

    function automatic req_t mk_req(input op_t op, input key_t ctl, input key_t act,
                                    input policy_t pol);
        req_t r;
        r.op           = op;
        r.control_id   = ctl;
        r.action_code  = act;
        r.policy_value = pol;
        return r;
    endfunction

    function automatic int find_entry(input key_t ctl, input key_t act);
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            if (shadow_valid[i] && shadow_ctl[i] == ctl && shadow_act[i] == act)
                return i;
        end
        return -1;
    endfunction

    task automatic apply_policy_req(input req_t r, output rsp_t result);
        int      slot;
        policy_t pol;
        pol    = r.policy_value & POLICY_MASK;
        result = '0;
        slot   = find_entry(r.control_id, r.action_code);
        case (r.op)
            OP_LOOKUP:
            begin
                if (slot >= 0)
                    result.policy_out = shadow_policy[slot];
            end
            OP_UPDATE:
            begin
                if (slot >= 0)
                begin
                    if (pol == '0)
                        shadow_valid[slot] = 1'b0;
                    else
                        shadow_policy[slot] = pol;
                end
                else if (pol != '0)
                begin
                    for (int i = 0; i < TABLE_ENTRIES && slot < 0; i++)
                    begin
                        if (!shadow_valid[i])
                            slot = i;
                    end
                    if (slot >= 0)
                    begin
                        shadow_valid[slot]  = 1'b1;
                        shadow_ctl[slot]    = r.control_id;
                        shadow_act[slot]    = r.action_code;
                        shadow_policy[slot] = pol;
                    end
                    else
                    begin
                        result.status = 1'b1;
                    end
                end
            end
            OP_CLEAR:
            begin
                for (int i = 0; i < TABLE_ENTRIES; i++)
                    shadow_valid[i] = 1'b0;
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin : check_rsp
        rsp_t want;
        if (rst_n && done)
        begin
            if (pending_rsp.size() == 0)
            begin
                report_mismatch("response with no request pending", int'(rsp), 0);
            end
            else
            begin
                want = pending_rsp.pop_front();
                if (rsp.policy_out !== want.policy_out)
                    report_mismatch("policy_out", int'(rsp.policy_out),
                                    int'(want.policy_out));
                if (rsp.status !== want.status)
                    report_mismatch("status", int'(rsp.status), int'(want.status));
            end
        end
    end

    task automatic hold_sender(input int cycles);
        @(negedge clk);
        start <= 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    task automatic send_req(input req_t r);
        rsp_t predicted;
        @(negedge clk);
        start <= 1'b1;
        req   <= r;
        @(posedge clk);
        while (busy) @(posedge clk);
        apply_policy_req(r, predicted);
        pending_rsp.push_back(predicted);
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            burst_left = $urandom_range(0, 30);
            hold_sender($urandom_range(1, 80));
        end
    endtask

    task automatic wait_for_idle();
        hold_sender(1);
        while (pending_rsp.size() != 0) @(posedge clk);
    endtask

    task automatic build_key_pool();
        pool_ctl[0] = '0;       pool_act[0] = '0;
        pool_ctl[1] = KEY_ONES; pool_act[1] = KEY_ONES;
        pool_ctl[2] = '0;       pool_act[2] = KEY_ONES;
        pool_ctl[3] = KEY_ONES; pool_act[3] = '0;
        for (int i = 4; i < KEY_POOL; i++)
        begin
            pool_ctl[i] = $urandom;
            pool_act[i] = $urandom;
            // share one half of the key with a neighbor
            if (i % 2 == 1)
                pool_ctl[i] = pool_ctl[i-1];
            else if (i % 4 == 2)
                pool_act[i] = pool_act[i-1];
        end
    endtask

    task automatic pick_key(output key_t ctl, output key_t act);
        int k;
        if ($urandom_range(0, 99) < 85)
        begin
            k   = $urandom_range(0, KEY_POOL - 1);
            ctl = pool_ctl[k];
            act = pool_act[k];
        end
        else
        begin
            ctl = $urandom;
            act = $urandom;
        end
    endtask

    function automatic policy_t rand_policy();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 12)
            return '0;
        else if (sel < 16)
            return POLICY_MASK;
        else if (sel < 20)
            return policy_t'(1);
        return policy_t'($urandom_range(1, 255));
    endfunction

    task automatic test_basic_ops();
        send_req(mk_req(OP_LOOKUP, '0, '0, '0));
        send_req(mk_req(OP_UPDATE, '0, '0, 8'hff));
        send_req(mk_req(OP_LOOKUP, '0, '0, '0));
        send_req(mk_req(OP_UPDATE, KEY_ONES, KEY_ONES, 8'h01));
        send_req(mk_req(OP_LOOKUP, KEY_ONES, KEY_ONES, '0));
        send_req(mk_req(OP_LOOKUP, '0, KEY_ONES, '0));
        send_req(mk_req(OP_UPDATE, '0, KEY_ONES, 8'haa));
        send_req(mk_req(OP_UPDATE, '0, '0, 8'h55));
        send_req(mk_req(OP_LOOKUP, '0, '0, '0));
        send_req(mk_req(OP_LOOKUP, KEY_ONES, KEY_ONES, 8'hff));
    endtask

    task automatic test_special_cases();
        send_req(mk_req(OP_UPDATE, KEY_ONES, KEY_ONES, '0));
        send_req(mk_req(OP_LOOKUP, KEY_ONES, KEY_ONES, '0));
        send_req(mk_req(OP_UPDATE, 32'h1234_5678, 32'h9abc_def0, '0));
        send_req(mk_req(OP_UNUSED, KEY_ONES, KEY_ONES, 8'hff));
        send_req(mk_req(OP_LOOKUP, '0, KEY_ONES, '0));
        send_req(mk_req(OP_CLEAR, KEY_ONES, KEY_ONES, 8'hff));
        send_req(mk_req(OP_LOOKUP, '0, KEY_ONES, '0));
        send_req(mk_req(OP_LOOKUP, '0, '0, '0));
        send_req(mk_req(OP_UPDATE, KEY_ONES, '0, 8'h80));
        send_req(mk_req(OP_LOOKUP, KEY_ONES, '0, '0));
        // hold off until every response is back
        wait_for_idle();
    endtask

    task automatic test_table_full();
        key_t fill_ctl [TABLE_ENTRIES];
        key_t fill_act [TABLE_ENTRIES];
        send_req(mk_req(OP_CLEAR, $urandom, $urandom, policy_t'($urandom_range(0, 255))));
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            fill_ctl[i] = $urandom;
            fill_act[i] = $urandom;
            send_req(mk_req(OP_UPDATE, fill_ctl[i], fill_act[i],
                            policy_t'($urandom_range(1, 255))));
        end
        for (int i = 0; i < 3; i++)
            send_req(mk_req(OP_UPDATE, $urandom, $urandom, policy_t'($urandom_range(1, 255))));
        send_req(mk_req(OP_UPDATE, fill_ctl[5], fill_act[5], POLICY_MASK));
        send_req(mk_req(OP_LOOKUP, fill_ctl[5], fill_act[5], '0));
        send_req(mk_req(OP_UPDATE, fill_ctl[10], fill_act[10], '0));
        send_req(mk_req(OP_UPDATE, pool_ctl[7], pool_act[7], 8'h3c));
        send_req(mk_req(OP_LOOKUP, pool_ctl[7], pool_act[7], '0));
        send_req(mk_req(OP_LOOKUP, fill_ctl[10], fill_act[10], '0));
        send_req(mk_req(OP_UPDATE, $urandom, $urandom, 8'h01));
    endtask

    task automatic test_random_mix();
        key_t ctl;
        key_t act;
        int   sel;
        op_t  op;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            pick_key(ctl, act);
            sel = $urandom_range(0, 199);
            if (sel < 80)
                op = OP_LOOKUP;
            else if (sel < 190)
                op = OP_UPDATE;
            else if (sel < 192)
                op = OP_CLEAR;
            else
                op = OP_UNUSED;
            if (op == OP_CLEAR || op == OP_UNUSED)
            begin
                ctl = $urandom;
                act = $urandom;
            end
            send_req(mk_req(op, ctl, act, rand_policy()));
            if (n == RANDOM_ITEMS / 2)
                wait_for_idle();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        req   = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            shadow_valid[i]  = 1'b0;
            shadow_ctl[i]    = '0;
            shadow_act[i]    = '0;
            shadow_policy[i] = '0;
        end
        build_key_pool();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_basic_ops();
        test_special_cases();
        test_table_full();
        test_random_mix();

        wait_for_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_rsp.size() == 0)
            $display("tb_keyed_policy_table passed");
        else
            $display("tb_keyed_policy_table failed");
        $finish;
    end

endmodule

`default_nettype wire
